/* sv/usd_pkg.sv */
`timescale 1ns / 1ps

package usd_pkg;

    // byte classes, decided from the byte alone
    typedef enum logic [2:0] {
        CLS_END   = 3'd0,
        CLS_ASCII = 3'd1,
        CLS_CONT  = 3'd2,
        CLS_LEAD2 = 3'd3,
        CLS_LEAD3 = 3'd4,
        CLS_LEAD4 = 3'd5,
        CLS_BAD   = 3'd6
    } t_cls;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_END      = 2'd1,
        ST_BAD_LEAD = 2'd2,
        ST_BAD_CONT = 2'd3
    } t_status;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned LEN_W = 3;

    localparam logic [7:0] ASCII_MAX = 8'd127;
    localparam logic [7:0] CONT_MIN  = 8'd128;
    localparam logic [7:0] CONT_MAX  = 8'd191;
    localparam logic [7:0] LEAD2_MIN = 8'd194;
    localparam logic [7:0] LEAD2_MAX = 8'd223;
    localparam logic [7:0] LEAD3_MIN = 8'd224;
    localparam logic [7:0] LEAD3_MAX = 8'd239;
    localparam logic [7:0] LEAD4_MIN = 8'd240;
    localparam logic [7:0] LEAD4_MAX = 8'd244;

    localparam logic [7:0] MASK_LEAD2 = 8'h1F;
    localparam logic [7:0] MASK_LEAD3 = 8'h0F;
    localparam logic [7:0] MASK_LEAD4 = 8'h07;
    localparam logic [7:0] MASK_CONT  = 8'h3F;

    // classified byte passed from front to back
    typedef struct packed {
        t_cls       cls;
        logic [6:0] bits;
    } t_tok;

    // one decoded result
    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
        t_status          status;
    } t_res;

endpackage

/* sv/utf8_stream_decoder.sv */
`timescale 1ns / 1ps

// UTF-8 stream decoder. One raw byte is taken per push transaction and the
// block sustains one byte per clock cycle unless stalled: the decode step
// that updates the remaining-byte count and partial code point handles one
// byte each cycle. A byte first enters a small queue of classified bytes;
// the decoder drains it into a result queue. Each completed sequence,
// end-of-string zero byte, bad lead byte or bad continuation byte yields
// one result; lead and middle bytes of a multi-byte sequence yield none.
// Either side may stall freely.
module utf8_stream_decoder
    import usd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2,
    parameter int unsigned OUT_DEPTH   = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       i_data_byte,
    output logic             empty,
    input  logic             pop,
    output logic [CP_W-1:0]  o_code_point,
    output logic [LEN_W-1:0] o_seq_length,
    output logic [1:0]       o_status
);

    logic tok_valid;
    logic tok_take;
    t_tok tok;

    // classify and queue incoming bytes
    usd_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .o_full      (full),
        .o_tok_valid (tok_valid),
        .o_tok       (tok),
        .i_tok_take  (tok_take)
    );

    // decode and queue results
    usd_back #(
        .DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tok_valid  (tok_valid),
        .i_tok        (tok),
        .o_tok_take   (tok_take),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_code_point (o_code_point),
        .o_seq_length (o_seq_length),
        .o_status     (o_status)
    );

endmodule

/* sv/usd_fifo.sv */
`timescale 1ns / 1ps

module usd_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full     = (r_count == FULL_CNT);
    assign o_empty    = (r_count == '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_data     = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // occupancy never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fifo count above depth");

    // a push into a full fifo leaves the count alone unless a pop happens
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |=> (r_count == FULL_CNT))
        else $error("fifo count changed while full");

endmodule

/* sv/usd_front.sv */
`timescale 1ns / 1ps

module usd_front
    import usd_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_data_byte,
    output logic       o_full,
    output logic       o_tok_valid,
    output t_tok       o_tok,
    input  logic       i_tok_take
);

    t_tok tok_in;
    logic tok_empty;

    // classify the byte and keep only its payload bits
    always_comb begin
        tok_in.bits = 7'd0;
        if (i_data_byte == 8'd0) begin
            tok_in.cls = CLS_END;
        end else if (i_data_byte <= ASCII_MAX) begin
            tok_in.cls  = CLS_ASCII;
            tok_in.bits = i_data_byte[6:0];
        end else if (i_data_byte >= CONT_MIN && i_data_byte <= CONT_MAX) begin
            tok_in.cls  = CLS_CONT;
            tok_in.bits = 7'(i_data_byte & MASK_CONT);
        end else if (i_data_byte >= LEAD2_MIN && i_data_byte <= LEAD2_MAX) begin
            tok_in.cls  = CLS_LEAD2;
            tok_in.bits = 7'(i_data_byte & MASK_LEAD2);
        end else if (i_data_byte >= LEAD3_MIN && i_data_byte <= LEAD3_MAX) begin
            tok_in.cls  = CLS_LEAD3;
            tok_in.bits = 7'(i_data_byte & MASK_LEAD3);
        end else if (i_data_byte >= LEAD4_MIN && i_data_byte <= LEAD4_MAX) begin
            tok_in.cls  = CLS_LEAD4;
            tok_in.bits = 7'(i_data_byte & MASK_LEAD4);
        end else begin
            tok_in.cls = CLS_BAD;
        end
    end

    // queue of classified bytes toward the decoder
    usd_fifo #(
        .WIDTH ($bits(t_tok)),
        .DEPTH (DEPTH)
    ) u_tok_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_data     (tok_in),
        .o_full     (o_full),
        .i_pop      (i_tok_take),
        .o_empty    (tok_empty),
        .o_data     (o_tok)
    );

    assign o_tok_valid = !tok_empty;

endmodule

/* sv/usd_back.sv */
`timescale 1ns / 1ps

module usd_back
    import usd_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tok_valid,
    input  t_tok             i_tok,
    output logic             o_tok_take,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [CP_W-1:0]  o_code_point,
    output logic [LEN_W-1:0] o_seq_length,
    output logic [1:0]       o_status
);

    logic [1:0]      r_bytes_left, n_bytes_left;
    logic [LEN_W-1:0] r_seq_total, n_seq_total;
    logic [CP_W-1:0] r_partial, n_partial;
    logic            res_push;
    t_res            res_in;
    t_res            res_out;
    logic            res_full;

    assign o_tok_take = i_tok_valid && !res_full;

    // decode step: one classified byte per transaction
    always_comb begin
        n_bytes_left = r_bytes_left;
        n_seq_total  = r_seq_total;
        n_partial    = r_partial;
        res_push     = 1'b0;
        res_in       = '{code_point: '0, seq_length: '0, status: ST_OK};
        if (o_tok_take) begin
            if (r_bytes_left == 2'd0) begin
                unique case (i_tok.cls)
                    CLS_END: begin
                        res_push      = 1'b1;
                        res_in.status = ST_END;
                    end
                    CLS_ASCII: begin
                        res_push          = 1'b1;
                        res_in.code_point = CP_W'(i_tok.bits);
                        res_in.seq_length = LEN_W'(1);
                    end
                    CLS_LEAD2: begin
                        n_partial    = CP_W'(i_tok.bits);
                        n_seq_total  = LEN_W'(2);
                        n_bytes_left = 2'd1;
                    end
                    CLS_LEAD3: begin
                        n_partial    = CP_W'(i_tok.bits);
                        n_seq_total  = LEN_W'(3);
                        n_bytes_left = 2'd2;
                    end
                    CLS_LEAD4: begin
                        n_partial    = CP_W'(i_tok.bits);
                        n_seq_total  = LEN_W'(4);
                        n_bytes_left = 2'd3;
                    end
                    default: begin
                        res_push      = 1'b1;
                        res_in.status = ST_BAD_LEAD;
                    end
                endcase
            end else if (i_tok.cls == CLS_CONT) begin
                // merge six more bits; finish on the last continuation
                if (r_bytes_left == 2'd1) begin
                    res_push          = 1'b1;
                    res_in.code_point = {r_partial[CP_W-7:0], i_tok.bits[5:0]};
                    res_in.seq_length = r_seq_total;
                    n_partial         = '0;
                    n_seq_total       = '0;
                    n_bytes_left      = 2'd0;
                end else begin
                    n_partial    = {r_partial[CP_W-7:0], i_tok.bits[5:0]};
                    n_bytes_left = r_bytes_left - 2'd1;
                end
            end else begin
                // broken sequence: report and drop back to idle
                res_push      = 1'b1;
                res_in.status = ST_BAD_CONT;
                n_partial     = '0;
                n_seq_total   = '0;
                n_bytes_left  = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 2'd0;
            r_seq_total  <= '0;
            r_partial    <= '0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_seq_total  <= n_seq_total;
            r_partial    <= n_partial;
        end
    end

    // result queue toward the consumer
    usd_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (DEPTH)
    ) u_res_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_push),
        .i_data     (res_in),
        .o_full     (res_full),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_data     (res_out)
    );

    assign o_code_point = res_out.code_point;
    assign o_seq_length = res_out.seq_length;
    assign o_status     = res_out.status;

    // idle means all sequence state is cleared
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes_left == 2'd0) |-> (r_seq_total == '0 && r_partial == '0))
        else $error("sequence state left over while idle");

    // an open sequence is longer than the bytes it still expects
    a_open_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes_left != 2'd0) |-> (r_seq_total > LEN_W'(r_bytes_left)))
        else $error("open sequence length inconsistent");

endmodule
